@@ sv/tensor_axis_reduce_top_macros.svh @@
// ----------------------------------------------------------------------------
// tensor_axis_reduce_top_macros
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef TENSOR_AXIS_REDUCE_TOP_MACROS_SVH
`define TENSOR_AXIS_REDUCE_TOP_MACROS_SVH

// same-cycle implication
`define TAR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/tar_pkg.sv @@
// ----------------------------------------------------------------------------
// tar_pkg
// shared types and constants of the tensor axis reduce block
// ----------------------------------------------------------------------------
`default_nettype none

package tar_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int EXT_W       = 13;
   localparam int CNT_W       = 12;
   localparam int DIMS        = 4;
   localparam int SLOT_IDX_W  = 6;
   localparam int SLOT_CNT_W  = 7;
   localparam int ACC_W       = 33;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [EXT_W-1:0] EXTENT_MAX = 13'd4096;
   localparam logic [ACC_W-1:0] ACC_SAT    = 33'h1_0000_0000;

   localparam logic [1:0] MODE_MEAN = 2'd0;
   localparam logic [1:0] MODE_SUM  = 2'd1;
   localparam logic [1:0] MODE_MIN  = 2'd2;
   localparam logic [1:0] MODE_MAX  = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] REG_MODE  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_START = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_EXT0  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_EXT1  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_EXT2  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_EXT3  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_MASK  = 3'd6;

   typedef struct packed {
      logic                       start;
      logic signed [SAMPLE_W-1:0] dividend;
      logic [ACC_W-1:0]           divisor;
   } div_ctl_type;

   // zero acts as one, values above range clamp
   function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] e);
      logic [EXT_W-1:0] r;
      r = e;
      if (e == '0) begin
         r = 13'd1;
      end else if (e > EXTENT_MAX) begin
         r = EXTENT_MAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/tar_ram.sv @@
// ----------------------------------------------------------------------------
// tar_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tar_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ sv/tar_divider.sv @@
// ----------------------------------------------------------------------------
// tar_divider
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module tar_divider (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire tar_pkg::div_ctl_type                 ctl,
   output logic                                      done,
   output logic signed [tar_pkg::SAMPLE_W-1:0]       quotient
);

   localparam int QW = tar_pkg::SAMPLE_W;
   localparam int RW = tar_pkg::ACC_W + 1;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [5:0]    count_ff, count_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic          neg_ff, neg_in;
   logic [tar_pkg::ACC_W-1:0] dvs_ff, dvs_in;
   logic [RW-1:0] rem_shift;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      dvs_in   = dvs_ff;
      rem_shift = {rem_ff[RW-2:0], quo_ff[QW-1]};
      if (ctl.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         neg_in   = ctl.dividend[QW-1];
         quo_in   = ctl.dividend[QW-1] ? (~ctl.dividend + 1'b1) : ctl.dividend;
         dvs_in   = ctl.divisor;
      end else if (busy_ff) begin
         if (rem_shift >= RW'(dvs_ff)) begin
            rem_in = rem_shift - RW'(dvs_ff);
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      neg_ff   <= neg_in;
      dvs_ff   <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (QW'(0) - quo_ff) : quo_ff;

endmodule

`default_nettype wire

@@ sv/tensor_axis_reduce_top.sv @@
// ----------------------------------------------------------------------------
// tensor_axis_reduce_top
// sum, mean, min or max of a row-major int32 tensor over masked axes
// ----------------------------------------------------------------------------
// Elements arrive on the req_ stream in row-major order, one per request.
// Mode, start value, the four extents and the axis mask are set through the
// csr_ write port, which the user must write only while the block is idle;
// the block does not enforce this. Writing any of them restarts the run.
// Per element, 4 steps of the shared multiply-add unit build the slot index
// over the kept axes, then a read-modify-write of the slot follows. The first
// element of a run first fills the accumulator ram with the initial value.
// After the final element, 8 multiply-add steps form the kept-slot count and
// the mean divisor, then each kept slot is read and sent on the rsp_ stream,
// in mean mode through the serial divider, one result at a time.
// req_tready is high only while no element or result is in flight.
// A stalled receiver simply holds the result register until it is taken.
// Reset restores the register defaults and clears the coordinate counters;
// the ram holds no reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module tensor_axis_reduce_top #(
   parameter int SLOT_COUNT = 64,
   parameter int MAX_RANK   = 4
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // sample [31:0]
   input  wire logic [tar_pkg::SAMPLE_W-1:0]           req_tdata,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // result_value [31:0], slot_index [37:32], zero fill [39:38]
   output logic [tar_pkg::RSP_TDATA_W-1:0]             rsp_tdata,
   // slot_overflow [0]
   output logic                                        rsp_tuser,
   output logic                                        rsp_tlast,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   input  wire logic                                   csr_we,
   input  wire logic [tar_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  wire logic [tar_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int DW = tar_pkg::SAMPLE_W;
   localparam int EW = tar_pkg::EXT_W;
   localparam int CW = tar_pkg::CNT_W;
   localparam int NW = tar_pkg::SLOT_CNT_W;
   localparam int XW = tar_pkg::ACC_W;
   localparam int PW = tar_pkg::ACC_W + tar_pkg::EXT_W;
   localparam logic [NW-1:0] SLOT_LAST = NW'(SLOT_COUNT - 1);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_FILL   = 10'b00_0000_0010,
      S_INDEX  = 10'b00_0000_0100,
      S_READ   = 10'b00_0000_1000,
      S_UPDATE = 10'b00_0001_0000,
      S_PREP   = 10'b00_0010_0000,
      S_FETCH  = 10'b00_0100_0000,
      S_CONV   = 10'b00_1000_0000,
      S_DIV    = 10'b01_0000_0000,
      S_OUT    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]    mode_ff, mode_in;
   logic [DW-1:0] start_ff, start_in;
   logic [EW-1:0] ext_ff [tar_pkg::DIMS];
   logic [EW-1:0] ext_in [tar_pkg::DIMS];
   logic [3:0]    mask_ff, mask_in;
   logic [CW-1:0] cnt_ff [tar_pkg::DIMS];
   logic [CW-1:0] cnt_in [tar_pkg::DIMS];
   logic          ovf_ff, ovf_in;
   logic [DW-1:0] sample_ff, sample_in;
   logic [2:0]    step_ff, step_in;
   logic [XW-1:0] slot_ff, slot_in;
   logic [XW-1:0] kept_ff, kept_in;
   logic [XW-1:0] div_ff, div_in;
   logic [NW-1:0] addr_ff, addr_in;
   logic [NW-1:0] n_ff, n_in;
   logic          last_ff, last_in;
   logic [DW-1:0] value_ff, value_in;

   logic [EW-1:0] eff [tar_pkg::DIMS];
   logic [1:0]    dim;
   logic [EW-1:0] mul_e;
   logic [XW-1:0] mul_x;
   logic [CW-1:0] mul_c;
   logic [PW-1:0] prod;
   logic [XW-1:0] prod_sat;
   logic          all_zero;
   logic          is_last;
   logic          carry;
   logic [DW-1:0] seed_value;
   logic [DW-1:0] fold;
   logic [DW-1:0] rdata;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [DW-1:0] ram_wdata;
   tar_pkg::div_ctl_type div_ctl;
   logic          div_done;
   logic signed [DW-1:0] div_quot;

   always_comb begin
      for (int d = 0; d < tar_pkg::DIMS; d++) begin
         eff[d] = (d < MAX_RANK) ? tar_pkg::eff_extent(ext_ff[d]) : EW'(1);
      end
   end

   always_comb begin
      all_zero = 1'b1;
      is_last  = 1'b1;
      for (int d = 0; d < tar_pkg::DIMS; d++) begin
         if (cnt_ff[d] != '0) begin
            all_zero = 1'b0;
         end
         if ((EW'(cnt_ff[d]) + EW'(1)) < eff[d]) begin
            is_last = 1'b0;
         end
      end
   end

   always_comb begin
      case (mode_ff)
         tar_pkg::MODE_MIN: seed_value = {1'b0, {(DW-1){1'b1}}};
         tar_pkg::MODE_MAX: seed_value = {1'b1, {(DW-1){1'b0}}};
         default:           seed_value = start_ff;
      endcase
   end

   always_comb begin
      case (mode_ff)
         tar_pkg::MODE_MIN:
            fold = ($signed(sample_ff) < $signed(rdata)) ? sample_ff : rdata;
         tar_pkg::MODE_MAX:
            fold = ($signed(sample_ff) > $signed(rdata)) ? sample_ff : rdata;
         default:
            fold = sample_ff + rdata;
      endcase
   end

   // shared multiply-add unit, saturated at 2^32
   assign dim = step_ff[1:0];
   assign mul_e = eff[dim];
   always_comb begin
      mul_c = '0;
      if (state_ff == S_INDEX) begin
         mul_x = slot_ff;
         mul_c = cnt_ff[dim];
      end else if (!step_ff[2]) begin
         mul_x = kept_ff;
      end else begin
         mul_x = div_ff;
      end
      prod     = PW'(mul_x) * PW'(mul_e) + PW'(mul_c);
      prod_sat = (prod > PW'(tar_pkg::ACC_SAT)) ? tar_pkg::ACC_SAT : prod[XW-1:0];
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      start_in  = start_ff;
      ext_in    = ext_ff;
      mask_in   = mask_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      sample_in = sample_ff;
      step_in   = step_ff;
      slot_in   = slot_ff;
      kept_in   = kept_ff;
      div_in    = div_ff;
      addr_in   = addr_ff;
      n_in      = n_ff;
      last_in   = last_ff;
      value_in  = value_ff;
      ram_we    = 1'b0;
      ram_waddr = addr_ff[AW-1:0];
      ram_wdata = seed_value;
      ram_raddr = addr_ff[AW-1:0];
      div_ctl.start    = 1'b0;
      div_ctl.dividend = rdata;
      div_ctl.divisor  = div_ff;
      carry = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_tdata;
               slot_in   = '0;
               step_in   = '0;
               addr_in   = '0;
               if (all_zero) begin
                  ovf_in   = 1'b0;
                  state_in = S_FILL;
               end else begin
                  state_in = S_INDEX;
               end
            end
         end
         S_FILL: begin
            ram_we  = 1'b1;
            addr_in = addr_ff + NW'(1);
            if (addr_ff == SLOT_LAST) begin
               state_in = S_INDEX;
            end
         end
         S_INDEX: begin
            if (!mask_ff[dim]) begin
               slot_in = prod_sat;
            end
            step_in = step_ff + 3'd1;
            if (dim == 2'd3) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            ram_raddr = slot_ff[AW-1:0];
            last_in   = is_last;
            state_in  = S_UPDATE;
         end
         S_UPDATE: begin
            ram_waddr = slot_ff[AW-1:0];
            ram_wdata = fold;
            if (slot_ff < XW'(SLOT_COUNT)) begin
               ram_we = 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            // odometer step, innermost dimension first
            for (int d = tar_pkg::DIMS - 1; d >= 0; d--) begin
               if (carry) begin
                  if ((EW'(cnt_ff[d]) + EW'(1)) < eff[d]) begin
                     cnt_in[d] = cnt_ff[d] + CW'(1);
                     carry     = 1'b0;
                  end else begin
                     cnt_in[d] = '0;
                  end
               end
            end
            step_in = '0;
            kept_in = XW'(1);
            div_in  = XW'(1);
            state_in = last_ff ? S_PREP : S_IDLE;
         end
         S_PREP: begin
            if (!step_ff[2] && !mask_ff[dim]) begin
               kept_in = prod_sat;
            end
            if (step_ff[2] && mask_ff[dim]) begin
               div_in = prod_sat;
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               addr_in = '0;
               if (kept_ff > XW'(SLOT_COUNT)) begin
                  ovf_in = 1'b1;
                  n_in   = NW'(SLOT_COUNT);
               end else begin
                  n_in   = kept_ff[NW-1:0];
               end
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_CONV;
         end
         S_CONV: begin
            if (mode_ff == tar_pkg::MODE_MEAN) begin
               div_ctl.start = 1'b1;
               state_in = S_DIV;
            end else begin
               value_in = rdata;
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            if (div_done) begin
               value_in = div_quot;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               if (addr_ff + NW'(1) == n_ff) begin
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  addr_in  = addr_ff + NW'(1);
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_addr)
            tar_pkg::REG_MODE:  mode_in   = csr_wdata[1:0];
            tar_pkg::REG_START: start_in  = csr_wdata;
            tar_pkg::REG_EXT0:  ext_in[0] = csr_wdata[EW-1:0];
            tar_pkg::REG_EXT1:  ext_in[1] = csr_wdata[EW-1:0];
            tar_pkg::REG_EXT2:  ext_in[2] = csr_wdata[EW-1:0];
            tar_pkg::REG_EXT3:  ext_in[3] = csr_wdata[EW-1:0];
            tar_pkg::REG_MASK:  mask_in   = csr_wdata[3:0];
            default: ;
         endcase
         if (csr_addr <= tar_pkg::REG_MASK) begin
            for (int d = 0; d < tar_pkg::DIMS; d++) begin
               cnt_in[d] = '0;
            end
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= tar_pkg::MODE_SUM;
         start_ff <= '0;
         mask_ff  <= 4'hf;
         ovf_ff   <= 1'b0;
         for (int d = 0; d < tar_pkg::DIMS; d++) begin
            ext_ff[d] <= EW'(1);
            cnt_ff[d] <= '0;
         end
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         start_ff <= start_in;
         mask_ff  <= mask_in;
         ovf_ff   <= ovf_in;
         ext_ff   <= ext_in;
         cnt_ff   <= cnt_in;
      end
      sample_ff <= sample_in;
      step_ff   <= step_in;
      slot_ff   <= slot_in;
      kept_ff   <= kept_in;
      div_ff    <= div_in;
      addr_ff   <= addr_in;
      n_ff      <= n_in;
      last_ff   <= last_in;
      value_ff  <= value_in;
   end

   tar_ram #(
      .WIDTH (DW),
      .DEPTH (SLOT_COUNT)
   ) u_acc_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (rdata)
   );

   tar_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {2'b00, addr_ff[tar_pkg::SLOT_IDX_W-1:0], value_ff};
   assign rsp_tlast  = (addr_ff + NW'(1) == n_ff);
   assign rsp_tuser  = ovf_ff;

endmodule

`default_nettype wire

@@ sv/tar_checker.sv @@
// ----------------------------------------------------------------------------
// tar_checker
// port-level checks of the tensor axis reduce block
// ----------------------------------------------------------------------------
`default_nettype none
`include "tensor_axis_reduce_top_macros.svh"

module tar_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic                               rsp_tlast,
   input wire logic [tar_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   `TAR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `TAR_ASSERT_NOW(a_no_req_while_rsp, clock, reset, rsp_tvalid, !req_tready, "request taken while a result is pending")
   `TAR_ASSERT_NEXT(a_burst_continues, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, !req_tready, "request taken mid-burst")
   `TAR_ASSERT_NEXT(a_req_busy, clock, reset, req_tvalid && req_tready, !req_tready, "back-to-back request accepted")

endmodule

bind tensor_axis_reduce_top tar_checker u_tar_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
